// File: hw/rtl/gsa_pkg.sv
// ============================================================================
// gsa_pkg
// Shared types and constants of the generational slot allocator.
// ============================================================================
package gsa_pkg;

    // Positions, the hint and the capacity all fit in 9 bits (slots 0..511)
    localparam int POS_W   = 9;
    localparam int CAP_W   = 9;
    localparam int LIVE_W  = 9;
    localparam int IDX_W   = 8;
    localparam int VER_W   = 16;

    // Largest pool reachable through a 9-bit capacity
    localparam int POOL    = 512;

    // Reserved marks are searched one chunk per cycle
    localparam int CHUNK_W     = 64;
    localparam int CHUNK_OFS_W = 6;
    localparam int CHUNK_SEL_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_FREE     = 2'd1,
        MODE_VALIDATE = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;     // write zero into the version memory, advance sweep
        logic capture;    // take the request into the working registers
        logic scan_step;  // examine one chunk of reserved marks
        logic commit;     // update pool state and load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  clr_last;
        logic  hit;
        logic  last_chunk;
        logic  out_free;
    } stat_t;

endpackage

// File: hw/rtl/gsa_ifs.sv
// ============================================================================
// gsa_ifs
// Request and response channels of the slot allocator (valid/ready).
// ============================================================================
interface gsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  slot_index;
    logic [15:0] slot_version;

    modport source (output valid, output mode, output slot_index, output slot_version,
                    input ready);
    modport sink   (input valid, input mode, input slot_index, input slot_version,
                    output ready);
endinterface

interface gsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  handle_index;
    logic [15:0] handle_version;
    logic [8:0]  live_count;

    modport source (output valid, output status, output handle_index,
                    output handle_version, output live_count, input ready);
    modport sink   (input valid, input status, input handle_index,
                    input handle_version, input live_count, output ready);
endinterface

// File: hw/rtl/gsa_ctrl.sv
// ============================================================================
// gsa_ctrl
// Sequencer: version memory sweep after reset, request capture, chunk scan,
// version read and commit into the result register.
// ============================================================================
module gsa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      in_mode,
    output logic            in_ready,
    input  gsa_pkg::stat_t  stat,
    output gsa_pkg::cmd_t   cmd
);

    gsa_pkg::state_t state_reg;
    gsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            gsa_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (gsa_pkg::mode_t'(in_mode))
                        gsa_pkg::MODE_ALLOC:    state_next = gsa_pkg::S_SCAN;
                        gsa_pkg::MODE_VALIDATE: state_next = gsa_pkg::S_READ;
                        default:                state_next = gsa_pkg::S_FINISH;
                    endcase
                end
            end
            gsa_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = gsa_pkg::S_READ;
                end
                else if (stat.last_chunk)
                begin
                    state_next = gsa_pkg::S_FINISH;  // pool full
                end
            end
            gsa_pkg::S_READ:
            begin
                state_next = gsa_pkg::S_FINISH;
            end
            gsa_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = gsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/gsa_datapath.sv
// ============================================================================
// gsa_datapath
// Pool state: reserved marks, version memory, live count, free hint,
// capacity register, chunked first-free search and the result register.
// ============================================================================
module gsa_datapath #(
    parameter int SLOTS        = 256,
    parameter int VERSION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gsa_pkg::cmd_t                 cmd,
    output gsa_pkg::stat_t                stat,
    input  logic [1:0]                    in_mode,
    input  logic [gsa_pkg::IDX_W-1:0]     in_index,
    input  logic [gsa_pkg::VER_W-1:0]     in_version,
    input  logic                          cfg_we,
    input  logic [gsa_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [1:0]                    out_status,
    output logic [gsa_pkg::IDX_W-1:0]     out_index,
    output logic [gsa_pkg::VER_W-1:0]     out_version,
    output logic [gsa_pkg::LIVE_W-1:0]    out_live
);

    // Only slots below the largest capacity are ever touched
    localparam int DEPTH  = (SLOTS < gsa_pkg::POOL) ? SLOTS : gsa_pkg::POOL;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VCMP_W = (VERSION_BITS > gsa_pkg::VER_W) ? VERSION_BITS : gsa_pkg::VER_W;
    localparam logic [gsa_pkg::POS_W:0] DEPTH_V = (gsa_pkg::POS_W + 1)'(DEPTH);

    localparam int PW = gsa_pkg::POS_W;
    localparam int CW = gsa_pkg::CHUNK_W;
    localparam int OW = gsa_pkg::CHUNK_OFS_W;
    localparam int SW = gsa_pkg::CHUNK_SEL_W;

    logic [gsa_pkg::CAP_W-1:0]  cap_reg,   cap_next;
    logic [DEPTH-1:0]           marks_reg, marks_next;
    logic [gsa_pkg::LIVE_W-1:0] live_reg,  live_next;
    logic [PW-1:0]              hint_reg,  hint_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic                       found_reg, found_next;
    logic                       out_valid_reg, out_valid_next;

    gsa_pkg::mode_t             mode_reg,  mode_next;
    logic [gsa_pkg::VER_W-1:0]  ver_reg,   ver_next;
    logic [PW-1:0]              pos_reg,   pos_next;
    logic [SW-1:0]              chunk_reg, chunk_next;
    logic [1:0]                 out_status_reg,  out_status_next;
    logic [gsa_pkg::IDX_W-1:0]  out_index_reg,   out_index_next;
    logic [gsa_pkg::VER_W-1:0]  out_version_reg, out_version_next;
    logic [gsa_pkg::LIVE_W-1:0] out_live_reg,    out_live_next;

    logic [VERSION_BITS-1:0]    mem [DEPTH];
    logic [VERSION_BITS-1:0]    rd_data_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [VERSION_BITS-1:0]    mem_wdata;

    logic [gsa_pkg::POOL-1:0]   marks_pad;
    logic [CW-1:0]              chunk_bits;
    logic [PW-1:0]              cap_eff;
    logic [PW-1:0]              cap_top;
    logic                       hit;
    logic [OW-1:0]              hit_ofs;
    logic [PW-1:0]              hit_pos;
    logic                       in_range;
    logic                       mark_at;
    logic [VERSION_BITS-1:0]    ver_inc;
    logic [VERSION_BITS-1:0]    ver_new;
    logic [VCMP_W-1:0]          ver_new_ext;
    logic                       ver_match;
    logic                       alloc_ok;

    // Slots beyond storage look reserved; the capacity clamp hides them anyway
    for (genvar k = 0; k < gsa_pkg::POOL; k++)
    begin : g_pad
        if (k < DEPTH)
        begin : g_slot
            assign marks_pad[k] = marks_reg[k];
        end
        else
        begin : g_none
            assign marks_pad[k] = 1'b1;
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = PW'(1);
        end
        else if ({1'b0, cap_reg} > DEPTH_V)
        begin
            cap_eff = DEPTH_V[PW-1:0];
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign cap_top = cap_eff - PW'(1);

    // First free slot in the current chunk at or above the hint, below capacity
    always_comb
    begin
        logic [PW-1:0] p;
        chunk_bits = marks_pad[{chunk_reg, {OW{1'b0}}} +: CW];
        hit        = 1'b0;
        hit_ofs    = '0;
        p          = '0;
        for (int j = CW - 1; j >= 0; j--)
        begin
            p = {chunk_reg, OW'(j)};
            if (!chunk_bits[j] && (p >= hint_reg) && (p < cap_eff))
            begin
                hit     = 1'b1;
                hit_ofs = OW'(j);
            end
        end
    end

    assign hit_pos   = {chunk_reg, hit_ofs};
    assign in_range  = ({1'b0, pos_reg} < DEPTH_V);
    assign mark_at   = in_range && marks_reg[pos_reg[AW-1:0]];
    assign ver_inc   = rd_data_reg + VERSION_BITS'(1);
    assign ver_new   = (ver_inc == '0) ? VERSION_BITS'(1) : ver_inc;
    assign ver_new_ext = VCMP_W'(ver_new);
    assign ver_match = (VCMP_W'(rd_data_reg) == VCMP_W'(ver_reg));
    assign alloc_ok  = (mode_reg == gsa_pkg::MODE_ALLOC) && found_reg;

    assign stat.clr_last   = (clr_cnt_reg == AW'(DEPTH - 1));
    assign stat.hit        = hit;
    assign stat.last_chunk = (chunk_reg >= cap_top[PW-1:OW]);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        cap_next         = cap_reg;
        marks_next       = marks_reg;
        live_next        = live_reg;
        hint_next        = hint_reg;
        clr_cnt_next     = clr_cnt_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        ver_next         = ver_reg;
        pos_next         = pos_reg;
        chunk_next       = chunk_reg;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        out_version_next = out_version_reg;
        out_live_next    = out_live_reg;

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        if (cmd.clr_wr)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.capture)
        begin
            mode_next  = gsa_pkg::mode_t'(in_mode);
            ver_next   = in_version;
            pos_next   = {1'b0, in_index};
            chunk_next = hint_reg[PW-1:OW];
            found_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            if (hit)
            begin
                found_next = 1'b1;
                pos_next   = hit_pos;
            end
            else
            begin
                chunk_next = chunk_reg + SW'(1);
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.commit)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = gsa_pkg::ST_OK;
            out_index_next   = '0;
            out_version_next = '0;
            case (mode_reg)
                gsa_pkg::MODE_ALLOC:
                begin
                    if (found_reg)
                    begin
                        marks_next[pos_reg[AW-1:0]] = 1'b1;
                        live_next        = live_reg + gsa_pkg::LIVE_W'(1);
                        hint_next        = pos_reg + PW'(1);
                        out_index_next   = pos_reg[gsa_pkg::IDX_W-1:0];
                        out_version_next = ver_new_ext[gsa_pkg::VER_W-1:0];
                    end
                    else
                    begin
                        out_status_next = gsa_pkg::ST_FULL;
                    end
                end
                gsa_pkg::MODE_FREE:
                begin
                    if (mark_at)
                    begin
                        marks_next[pos_reg[AW-1:0]] = 1'b0;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - gsa_pkg::LIVE_W'(1);
                        end
                        if (pos_reg < hint_reg)
                        begin
                            hint_next = pos_reg;
                        end
                    end
                    else
                    begin
                        out_status_next = gsa_pkg::ST_BAD;
                    end
                end
                gsa_pkg::MODE_VALIDATE:
                begin
                    // version 0 is the null handle
                    if (!((ver_reg != '0) && mark_at && ver_match))
                    begin
                        out_status_next = gsa_pkg::ST_BAD;
                    end
                end
                default:
                begin
                    marks_next = '0;
                    live_next  = '0;
                    hint_next  = '0;
                end
            endcase
            out_live_next = live_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= gsa_pkg::CAP_RESET;
            marks_reg     <= '0;
            live_reg      <= '0;
            hint_reg      <= '0;
            clr_cnt_reg   <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            marks_reg     <= marks_next;
            live_reg      <= live_next;
            hint_reg      <= hint_next;
            clr_cnt_reg   <= clr_cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        ver_reg         <= ver_next;
        pos_reg         <= pos_next;
        chunk_reg       <= chunk_next;
        out_status_reg  <= out_status_next;
        out_index_reg   <= out_index_next;
        out_version_reg <= out_version_next;
        out_live_reg    <= out_live_next;
    end

    // Version memory: one write port, one registered read port
    assign mem_we    = cmd.clr_wr || (cmd.commit && alloc_ok);
    assign mem_waddr = cmd.clr_wr ? clr_cnt_reg : pos_reg[AW-1:0];
    assign mem_wdata = cmd.clr_wr ? '0 : ver_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[pos_reg[AW-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_index   = out_index_reg;
    assign out_version = out_version_reg;
    assign out_live    = out_live_reg;

endmodule

// File: hw/rtl/generational_slot_allocator.sv
// ============================================================================
// generational_slot_allocator
// Pool of slots handed out as index plus version handles.
// ============================================================================
// After reset the block sweeps its version memory to zero, one entry per
// cycle, over min(SLOTS, 512) entries, and takes no request until then;
// capacity writes are taken at any time. One request is worked on at a time.
// Free and clear-all go from the accepted request straight to the commit;
// validate first does one registered version memory read; allocate first
// searches 64-slot chunks of reserved marks chunk by chunk from the chunk of
// the lowest-free hint, then reads the version; a full pool skips the read.
// A finished result sits in an output register, so the next request is
// taken while it waits for its transfer.
// ============================================================================
module generational_slot_allocator #(
    parameter int SLOTS        = 256,
    parameter int VERSION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gsa_req_if.sink                    req,
    gsa_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [gsa_pkg::CAP_W-1:0]  cfg_wdata
);

    gsa_pkg::cmd_t  cmd;
    gsa_pkg::stat_t stat;

    gsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsa_datapath #(
        .SLOTS        (SLOTS),
        .VERSION_BITS (VERSION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (req.mode),
        .in_index    (req.slot_index),
        .in_version  (req.slot_version),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_status  (rsp.status),
        .out_index   (rsp.handle_index),
        .out_version (rsp.handle_version),
        .out_live    (rsp.live_count)
    );

    // A result is only loaded when the result register is free or draining
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over a pending result");

    // After a commit the block is ready for the next request
    a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> req.ready)
        else $error("not ready after commit");

    // A nonzero handle version comes only with a successful allocate
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.handle_version != '0))
            |-> ((rsp.status == gsa_pkg::ST_OK) && (rsp.live_count != '0)))
        else $error("handle returned without a reserved slot");

endmodule
